/* hdl/dhht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhht_pkg: shared types and constants of the double hashing hash table
// Field widths, status and action codes, register indexes, queue items
// and controller state encodings.
// ----------------------------------------------------------------------------
package dhht_pkg;

   localparam int KEY_W       = 31;
   localparam int SIZE_W      = 10;
   localparam int PROBE_W     = 7;
   localparam int SLOT_W      = 9;
   localparam int STATUS_W    = 3;
   localparam int BIT_CNT_W   = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 10'd512;
   localparam logic [SIZE_W-1:0]  MIN_SIZE    = 10'd2;
   localparam logic [PROBE_W-1:0] LIMIT_RESET = 7'd50;
   localparam logic [PROBE_W-1:0] MIN_PROBES  = 7'd1;
   localparam logic [PROBE_W-1:0] PROBE_CAP   = 7'd64;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_LIMIT = 2'd1;

   typedef struct packed {
      logic              action;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [PROBE_W-1:0]  probes_used;
   } rsp_type;

   // hashed request handed from the front end to the probe engine
   typedef struct packed {
      logic               action;
      logic [KEY_W-1:0]   key;
      logic [SIZE_W-1:0]  pos;
      logic [SIZE_W-1:0]  step;
      logic [SIZE_W-1:0]  size;
      logic [PROBE_W-1:0] limit;
   } work_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_CLEAR,
      BACK_IDLE,
      BACK_READ,
      BACK_CHECK,
      BACK_RESULT
   } back_state_type;

endpackage
`default_nettype wire

/* hdl/dhht_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhht_fifo: small register queue
// Holds up to QUEUE_DEPTH transactions; head is shown while not empty.
// ----------------------------------------------------------------------------
module dhht_fifo #(
   parameter int WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);
   import dhht_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

/* hdl/dhht_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhht_front: request intake and hashing
// Clamps the table size and probe limit, then reduces the key modulo size
// and size-1 with two restoring remainder units, one key bit per cycle.
// ----------------------------------------------------------------------------
module dhht_front #(
   parameter int DEPTH = 512
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire dhht_pkg::req_type             req,
   input  wire logic [dhht_pkg::SIZE_W-1:0]   size_cfg,
   input  wire logic [dhht_pkg::PROBE_W-1:0]  limit_cfg,
   input  wire logic                          queue_full,
   output logic                               busy,
   output logic                               queue_push,
   output dhht_pkg::work_type                 work
);
   import dhht_pkg::*;

   front_state_type         state_ff, state_in;
   logic                    action_ff, action_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [KEY_W-1:0]        key_sh_ff, key_sh_in;
   logic [SIZE_W-1:0]       rem1_ff, rem1_in;
   logic [SIZE_W-1:0]       rem2_ff, rem2_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [SIZE_W-1:0]       size_ff, size_in;
   logic [PROBE_W-1:0]      limit_ff, limit_in;

   logic [SIZE_W-1:0]       eff_size;
   logic [PROBE_W-1:0]      eff_limit;
   logic [SIZE_W:0]         trial1, trial2, div1, div2;

   always_comb begin
      eff_size = size_cfg;
      if (size_cfg < MIN_SIZE) begin
         eff_size = MIN_SIZE;
      end else if ({{(32-SIZE_W){1'b0}}, size_cfg} > 32'(DEPTH)) begin
         eff_size = SIZE_W'(DEPTH);
      end
      eff_limit = limit_cfg;
      if (limit_cfg < MIN_PROBES) begin
         eff_limit = MIN_PROBES;
      end else if (limit_cfg > PROBE_CAP) begin
         eff_limit = PROBE_CAP;
      end
   end

   // one restoring step for each remainder
   assign trial1 = {rem1_ff, key_sh_ff[KEY_W-1]};
   assign trial2 = {rem2_ff, key_sh_ff[KEY_W-1]};
   assign div1   = {1'b0, size_ff};
   assign div2   = {1'b0, size_ff - 1'b1};

   assign work = '{action: action_ff, key: key_ff, pos: rem1_ff,
                   step: rem2_ff + 1'b1, size: size_ff, limit: limit_ff};

   always_comb begin
      state_in   = state_ff;
      action_in  = action_ff;
      key_in     = key_ff;
      key_sh_in  = key_sh_ff;
      rem1_in    = rem1_ff;
      rem2_in    = rem2_ff;
      bit_cnt_in = bit_cnt_ff;
      size_in    = size_ff;
      limit_in   = limit_ff;
      busy       = 1'b1;
      queue_push = 1'b0;
      unique case (state_ff)
         FRONT_IDLE: begin
            busy = 1'b0;
            if (start) begin
               action_in  = req.action;
               key_in     = req.key;
               key_sh_in  = req.key;
               rem1_in    = '0;
               rem2_in    = '0;
               bit_cnt_in = BIT_CNT_W'(KEY_W - 1);
               size_in    = eff_size;
               limit_in   = eff_limit;
               state_in   = FRONT_DIVIDE;
            end
         end
         FRONT_DIVIDE: begin
            rem1_in   = (trial1 >= div1) ? SIZE_W'(trial1 - div1) : trial1[SIZE_W-1:0];
            rem2_in   = (trial2 >= div2) ? SIZE_W'(trial2 - div2) : trial2[SIZE_W-1:0];
            key_sh_in = {key_sh_ff[KEY_W-2:0], 1'b0};
            if (bit_cnt_ff == '0) begin
               state_in = FRONT_PUSH;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         FRONT_PUSH: begin
            if (!queue_full) begin
               queue_push = 1'b1;
               state_in   = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      key_ff     <= key_in;
      key_sh_ff  <= key_sh_in;
      rem1_ff    <= rem1_in;
      rem2_ff    <= rem2_in;
      bit_cnt_ff <= bit_cnt_in;
      size_ff    <= size_in;
      limit_ff   <= limit_in;
   end

endmodule
`default_nettype wire

/* hdl/dhht_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhht_back: probe engine
// Owns the key and occupancy memories, sweeps occupancy clear after reset,
// and walks the probe sequence for one hashed request at a time.
// ----------------------------------------------------------------------------
module dhht_back #(
   parameter int DEPTH = 512
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               queue_empty,
   input  wire dhht_pkg::work_type work,
   output logic                    queue_pop,
   input  wire logic               rsp_full,
   output logic                    rsp_push,
   output dhht_pkg::rsp_type       rsp,
   output logic                    clearing
);
   import dhht_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                used_mem [DEPTH];
   logic [KEY_W-1:0]    key_mem  [DEPTH];
   logic                used_rd_ff;
   logic [KEY_W-1:0]    key_rd_ff;

   back_state_type      state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   work_type            item_ff, item_in;
   logic [SIZE_W-1:0]   pos_ff, pos_in;
   logic [PROBE_W-1:0]  count_ff, count_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [AW+SIZE_W-1:0] pos_wide;
   logic [AW-1:0]        probe_addr;
   logic [AW-1:0]        used_addr;
   logic                 used_we, used_wd, key_we;
   logic [SIZE_W:0]      pos_sum;

   assign pos_wide   = {{AW{1'b0}}, pos_ff};
   assign probe_addr = pos_wide[AW-1:0];
   assign pos_sum    = {1'b0, pos_ff} + {1'b0, item_ff.step};
   assign used_addr  = (state_ff == BACK_CLEAR) ? clr_ff : probe_addr;

   assign clearing = (state_ff == BACK_CLEAR);
   assign rsp      = '{status: status_ff, slot: pos_ff[SLOT_W-1:0],
                       probes_used: count_ff};

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      item_in   = item_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      status_in = status_ff;
      queue_pop = 1'b0;
      rsp_push  = 1'b0;
      used_we   = 1'b0;
      used_wd   = 1'b0;
      key_we    = 1'b0;
      unique case (state_ff)
         BACK_CLEAR: begin
            used_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               item_in   = work;
               pos_in    = work.pos;
               count_in  = PROBE_W'(1);
               state_in  = BACK_READ;
            end
         end
         BACK_READ: begin
            state_in = BACK_CHECK;
         end
         BACK_CHECK: begin
            if (!used_rd_ff) begin
               if (item_ff.action == ACTION_SEARCH) begin
                  status_in = STATUS_NOT_FOUND;
               end else begin
                  used_we   = 1'b1;
                  used_wd   = 1'b1;
                  key_we    = 1'b1;
                  status_in = STATUS_INSERTED;
               end
               state_in = BACK_RESULT;
            end else if (key_rd_ff == item_ff.key) begin
               status_in = (item_ff.action == ACTION_SEARCH) ? STATUS_FOUND : STATUS_PRESENT;
               state_in  = BACK_RESULT;
            end else if (count_ff == item_ff.limit) begin
               status_in = (item_ff.action == ACTION_SEARCH) ? STATUS_NOT_FOUND
                                                             : STATUS_DROPPED;
               state_in  = BACK_RESULT;
            end else begin
               // next probe wraps modulo the table size
               pos_in   = (pos_sum >= {1'b0, item_ff.size})
                          ? SIZE_W'(pos_sum - {1'b0, item_ff.size})
                          : pos_sum[SIZE_W-1:0];
               count_in = count_ff + 1'b1;
               state_in = BACK_READ;
            end
         end
         BACK_RESULT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      pos_ff    <= pos_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_addr] <= used_wd;
      end
      used_rd_ff <= used_mem[probe_addr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[probe_addr] <= item_ff.key;
      end
      key_rd_ff <= key_mem[probe_addr];
   end

endmodule
`default_nettype wire

/* hdl/double_hashing_hash_table.sv */
// A request passes the front end, the middle queue, the probe engine and the response queue.
// The front end forms the two key remainders one bit a cycle and takes no new request
// until it has pushed the last one into the middle queue; the probe engine works on one
// request at a time, with a registered read of the slot memories before each probe check.
// Reset: synchronous; afterwards full stays high while the occupancy memory is swept
// clear. Registers return to 512 and 50.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_hashing_hash_table: open-addressing hash set with double hashing
// Queue-style request and response ports plus a register write channel.
// ----------------------------------------------------------------------------
module double_hashing_hash_table #(
   parameter int DEPTH = 512
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   output logic                                  full,
   input  wire dhht_pkg::req_type                req_data,
   output logic                                  empty,
   input  wire logic                             pop,
   output dhht_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dhht_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dhht_pkg::CSR_DATA_W-1:0]  csr_data
);
   import dhht_pkg::*;

   logic [SIZE_W-1:0]  size_cfg_ff, size_cfg_in;
   logic [PROBE_W-1:0] limit_cfg_ff, limit_cfg_in;

   logic     start, front_busy, clearing;
   logic     mid_push, mid_full, mid_pop, mid_empty;
   work_type front_work, mid_work;
   logic     rsp_push, rsp_full;
   rsp_type  back_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      size_cfg_in  = size_cfg_ff;
      limit_cfg_in = limit_cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SLOT_COUNT:  size_cfg_in  = csr_data[SIZE_W-1:0];
            CSR_PROBE_LIMIT: limit_cfg_in = csr_data[PROBE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_cfg_ff  <= SIZE_RESET;
         limit_cfg_ff <= LIMIT_RESET;
      end else begin
         size_cfg_ff  <= size_cfg_in;
         limit_cfg_ff <= limit_cfg_in;
      end
   end

   assign full  = front_busy | clearing;
   assign start = push & ~full;

   dhht_front #(
      .DEPTH(DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_data),
      .size_cfg   (size_cfg_ff),
      .limit_cfg  (limit_cfg_ff),
      .queue_full (mid_full),
      .busy       (front_busy),
      .queue_push (mid_push),
      .work       (front_work)
   );

   dhht_fifo #(
      .WIDTH($bits(work_type))
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mid_push),
      .wr_data (front_work),
      .full    (mid_full),
      .rd_en   (mid_pop),
      .rd_data (mid_work),
      .empty   (mid_empty)
   );

   dhht_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (mid_empty),
      .work        (mid_work),
      .queue_pop   (mid_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp         (back_rsp),
      .clearing    (clearing)
   );

   dhht_fifo #(
      .WIDTH($bits(rsp_type))
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

endmodule
`default_nettype wire

/* hdl/dhht_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhht_checker: port-level checks for the hash table
// Watches the queue ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module dhht_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              full,
   input wire logic              empty,
   input wire logic              pop,
   input wire dhht_pkg::rsp_type rsp_data
);
   import dhht_pkg::*;

   // occupancy sweep keeps intake closed right after reset
   assert property (@(posedge clock) reset |=> full)
      else $error("intake open right after reset");

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.status == STATUS_INSERTED || rsp_data.status == STATUS_PRESENT ||
                  rsp_data.status == STATUS_DROPPED || rsp_data.status == STATUS_FOUND ||
                  rsp_data.status == STATUS_NOT_FOUND))
      else $error("undefined status code");

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.probes_used != '0 && rsp_data.probes_used <= PROBE_CAP))
      else $error("probe count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind double_hashing_hash_table dhht_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the double hashing hash table
// Sends insert and search transactions through the request queue, changes
// table size and probe limit between phases, and checks every response field
// against a behavioral model of probes and slot contents, or a typed-in one.
// ----------------------------------------------------------------------------
module tb_top;
   import dhht_pkg::*;

   localparam int TABLE_DEPTH = 512;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 200;
   localparam int PHASE_ITEMS = 104;
   localparam int NUM_PHASES  = 8;
   localparam int POOL_MAX    = 64;
   localparam int MAX_PRINTS  = 60;

   // index with no register behind it, writes are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd2;

   typedef enum logic [1:0] {
      ROW_CONFIG,
      ROW_CHECKED,
      ROW_FIXED
   } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      req_type               item;
      rsp_type               want;
      logic [CSR_DATA_W-1:0] size_val;
      logic [CSR_DATA_W-1:0] probe_val;
      bit                    spare;
   } row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   push      = 1'b0;
   logic                   full;
   req_type                req_data  = '0;
   logic                   empty;
   logic                   pop       = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // typed-in response that travels with a directed request
   logic    want_fixed = 1'b0;
   rsp_type want_rsp   = '0;

   // model of the table contents and registers
   logic               occupied   [0:TABLE_DEPTH-1];
   logic [KEY_W-1:0]   stored_key [0:TABLE_DEPTH-1];
   logic [SIZE_W-1:0]  size_reg;
   logic [PROBE_W-1:0] probes_reg;

   rsp_type          pending_rsp [$];
   logic [KEY_W-1:0] key_pool [$];
   row_type          plan [$];
   int unsigned      sent_count    = 0;
   int unsigned      checked_count = 0;
   int unsigned      error_count   = 0;
   int unsigned      popped_count  = 0;
   int               pop_wait      = 0;

   double_hashing_hash_table #(
      .DEPTH(TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #24_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // walks the double hash probe sequence, updates the model table on insert
   function automatic rsp_type probe_table(req_type r);
      int unsigned size;
      int unsigned limit;
      int unsigned pos;
      int unsigned step;
      int unsigned last;
      int unsigned i;
      bit          done;
      rsp_type     res;
      size = size_reg;
      if (size < MIN_SIZE) size = MIN_SIZE;
      if (size > TABLE_DEPTH) size = TABLE_DEPTH;
      limit = probes_reg;
      if (limit < MIN_PROBES) limit = MIN_PROBES;
      if (limit > PROBE_CAP) limit = PROBE_CAP;
      pos  = r.key % size;
      step = 1 + r.key % (size - 1);
      res.status      = (r.action == ACTION_SEARCH) ? STATUS_NOT_FOUND : STATUS_DROPPED;
      res.probes_used = PROBE_W'(limit);
      last = pos;
      done = 1'b0;
      for (i = 0; i < limit && !done; i++) begin
         last = pos;
         if (!occupied[pos]) begin
            if (r.action == ACTION_INSERT) begin
               occupied[pos]   = 1'b1;
               stored_key[pos] = r.key;
               res.status      = STATUS_INSERTED;
            end else begin
               res.status = STATUS_NOT_FOUND;
            end
            done = 1'b1;
         end else if (stored_key[pos] == r.key) begin
            res.status = (r.action == ACTION_SEARCH) ? STATUS_FOUND : STATUS_PRESENT;
            done = 1'b1;
         end else begin
            pos += step;
            if (pos >= size) pos -= size;
         end
         if (done) res.probes_used = PROBE_W'(i + 1);
      end
      res.slot = SLOT_W'(last);
      return res;
   endfunction

   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40 && key_pool.size() != 0) begin
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      if (r < 46) return ($urandom_range(0, 1) != 0) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
      // narrow keys pile up on the same slots
      if (r < 76) return KEY_W'($urandom_range(0, 4095));
      return KEY_W'($urandom());
   endfunction

   function automatic row_type config_row(logic [CSR_DATA_W-1:0] sz,
                                          logic [CSR_DATA_W-1:0] pr, bit spare);
      row_type r;
      r.kind      = ROW_CONFIG;
      r.item      = '0;
      r.want      = '0;
      r.size_val  = sz;
      r.probe_val = pr;
      r.spare     = spare;
      return r;
   endfunction

   function automatic row_type lookup_row(logic action, logic [KEY_W-1:0] key, bit fixed,
                                          logic [STATUS_W-1:0] status, int slot, int probes);
      row_type r;
      r.kind             = fixed ? ROW_FIXED : ROW_CHECKED;
      r.item.action      = action;
      r.item.key         = key;
      r.want.status      = status;
      r.want.slot        = SLOT_W'(slot);
      r.want.probes_used = PROBE_W'(probes);
      r.size_val         = '0;
      r.probe_val        = '0;
      r.spare            = 1'b0;
      return r;
   endfunction

   function automatic void add_row(row_type r);
      plan.insert(plan.size(), r);
   endfunction

   task automatic send_item(req_type item, bit fixed, rsp_type want, int gap);
      push       <= 1'b1;
      req_data   <= item;
      want_fixed <= fixed;
      want_rsp   <= want;
      @(posedge clock);
      while (full) @(posedge clock);
      sent_count++;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      if (push) push <= 1'b0;
      while (checked_count < sent_count) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] size_val,
                             logic [CSR_DATA_W-1:0] probe_val, bit spare);
      wait_drained();
      write_reg(CSR_SLOT_COUNT, size_val);
      write_reg(CSR_PROBE_LIMIT, probe_val);
      if (spare) write_reg(CSR_SPARE, ~size_val);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type exp_rsp;
      int      s;
      if (reset) begin
         for (s = 0; s < TABLE_DEPTH; s++) occupied[s] = 1'b0;
         size_reg   = SIZE_RESET;
         probes_reg = LIMIT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLOT_COUNT:  size_reg = csr_data[SIZE_W-1:0];
               CSR_PROBE_LIMIT: probes_reg = csr_data[PROBE_W-1:0];
               default: ;
            endcase
         end
         if (push && !full) begin
            exp_rsp = probe_table(req_data);
            pending_rsp.insert(pending_rsp.size(), want_fixed ? want_rsp : exp_rsp);
         end
         if (pop && !empty) begin
            if (pending_rsp.size() == 0) begin
               flag_error($sformatf("response with nothing outstanding, status %0d",
                                    rsp_data.status));
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_data.status !== exp_rsp.status)
                  flag_error($sformatf("status got %0d want %0d",
                                       rsp_data.status, exp_rsp.status));
               if (rsp_data.slot !== exp_rsp.slot)
                  flag_error($sformatf("slot got %0d want %0d",
                                       rsp_data.slot, exp_rsp.slot));
               if (rsp_data.probes_used !== exp_rsp.probes_used)
                  flag_error($sformatf("probes_used got %0d want %0d",
                                       rsp_data.probes_used, exp_rsp.probes_used));
            end
            checked_count++;
         end
      end
   end

   // response side: random pop gaps, two long hold-offs to back up the queue
   always @(posedge clock) begin : drain_ctl
      int g;
      if (reset) begin
         pop      <= 1'b0;
         pop_wait <= 0;
      end else if (pop_wait > 1) begin
         pop_wait <= pop_wait - 1;
      end else if (pop_wait == 1 || !pop) begin
         pop_wait <= 0;
         pop      <= 1'b1;
      end else if (!empty) begin
         popped_count <= popped_count + 1;
         if (popped_count == 150 || popped_count == 520) g = HOLD_CYCLES;
         else g = pick_gap((popped_count % 128) < 24);
         if (g > 0) begin
            pop      <= 1'b0;
            pop_wait <= g;
         end
      end
   end

   initial begin : stimulus
      int                    n;
      int                    ph;
      logic [CSR_DATA_W-1:0] sz;
      logic [CSR_DATA_W-1:0] pr;
      req_type               item;

      // empty table after the clearing pass, default size and limit
      add_row(lookup_row(ACTION_SEARCH, 31'd0, 1'b1, STATUS_NOT_FOUND, 0, 1));
      add_row(lookup_row(ACTION_INSERT, 31'd0, 1'b1, STATUS_INSERTED, 0, 1));
      add_row(lookup_row(ACTION_INSERT, 31'd0, 1'b1, STATUS_PRESENT, 0, 1));
      add_row(lookup_row(ACTION_SEARCH, 31'd0, 1'b1, STATUS_FOUND, 0, 1));
      add_row(lookup_row(ACTION_INSERT, 31'h7FFFFFFF, 1'b1, STATUS_INSERTED, 511, 1));
      add_row(lookup_row(ACTION_SEARCH, 31'h7FFFFFFF, 1'b1, STATUS_FOUND, 511, 1));
      // collision on slot 0, second hash moves on
      add_row(lookup_row(ACTION_INSERT, 31'd512, 1'b1, STATUS_INSERTED, 2, 2));
      add_row(lookup_row(ACTION_SEARCH, 31'd1024, 1'b1, STATUS_NOT_FOUND, 3, 2));
      add_row(lookup_row(ACTION_INSERT, 31'h55555555, 1'b0, STATUS_INSERTED, 0, 0));
      add_row(lookup_row(ACTION_INSERT, 31'h2AAAAAAA, 1'b0, STATUS_INSERTED, 0, 0));
      // smallest table, full probe limit runs out
      add_row(config_row(10'd2, 10'd64, 1'b0));
      add_row(lookup_row(ACTION_INSERT, 31'd1, 1'b1, STATUS_INSERTED, 1, 1));
      add_row(lookup_row(ACTION_INSERT, 31'd3, 1'b1, STATUS_DROPPED, 0, 64));
      add_row(lookup_row(ACTION_SEARCH, 31'd5, 1'b1, STATUS_NOT_FOUND, 0, 64));
      add_row(lookup_row(ACTION_SEARCH, 31'd0, 1'b1, STATUS_FOUND, 0, 1));
      // register values below range saturate to size 2, one probe
      add_row(config_row(10'd0, 10'd0, 1'b0));
      add_row(lookup_row(ACTION_INSERT, 31'd3, 1'b1, STATUS_DROPPED, 1, 1));
      add_row(lookup_row(ACTION_SEARCH, 31'd2, 1'b1, STATUS_NOT_FOUND, 0, 1));
      // values above range saturate to full depth, 64 probes
      add_row(config_row(10'h3FF, 10'h3FF, 1'b1));
      add_row(lookup_row(ACTION_SEARCH, 31'h7FFFFFFF, 1'b1, STATUS_FOUND, 511, 1));
      add_row(lookup_row(ACTION_INSERT, 31'd3, 1'b1, STATUS_INSERTED, 3, 1));
      add_row(lookup_row(ACTION_INSERT, 31'd1, 1'b1, STATUS_PRESENT, 1, 1));
      add_row(config_row(10'd511, 10'd64, 1'b0));
      add_row(lookup_row(ACTION_INSERT, 31'd511, 1'b0, STATUS_INSERTED, 0, 0));
      add_row(lookup_row(ACTION_INSERT, 31'd1022, 1'b0, STATUS_INSERTED, 0, 0));
      add_row(lookup_row(ACTION_INSERT, 31'd1533, 1'b0, STATUS_INSERTED, 0, 0));
      add_row(lookup_row(ACTION_SEARCH, 31'd1022, 1'b0, STATUS_INSERTED, 0, 0));
      add_row(config_row(10'd3, 10'd2, 1'b0));
      add_row(lookup_row(ACTION_INSERT, 31'd7, 1'b0, STATUS_INSERTED, 0, 0));
      add_row(lookup_row(ACTION_SEARCH, 31'd7, 1'b0, STATUS_INSERTED, 0, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < plan.size(); n++) begin
         if (plan[n].kind == ROW_CONFIG) begin
            set_config(plan[n].size_val, plan[n].probe_val, plan[n].spare);
         end else begin
            send_item(plan[n].item, plan[n].kind == ROW_FIXED, plan[n].want,
                      pick_gap(1'b0));
         end
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin
               sz = 10'd512;
               pr = 10'd50;
            end
            1: begin
               sz = CSR_DATA_W'($urandom_range(4, 40));
               pr = CSR_DATA_W'($urandom_range(1, 64));
            end
            2: begin
               sz = 10'd2;
               pr = 10'd64;
            end
            3: begin
               // upper data bits of the probe limit are dropped
               sz = CSR_DATA_W'($urandom_range(2, 512));
               pr = CSR_DATA_W'($urandom_range(0, 1023));
            end
            4: begin
               sz = CSR_DATA_W'($urandom_range(513, 1023));
               pr = 10'd127;
            end
            5: begin
               sz = CSR_DATA_W'($urandom_range(0, 1));
               pr = 10'd0;
            end
            6: begin
               sz = 10'd511;
               pr = 10'd64;
            end
            default: begin
               sz = CSR_DATA_W'($urandom_range(2, 512));
               pr = CSR_DATA_W'($urandom_range(1, 64));
            end
         endcase
         set_config(sz, pr, ph == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 4 && n == 50) wait_drained();
            item.action = ($urandom_range(0, 99) < 55) ? ACTION_INSERT : ACTION_SEARCH;
            item.key    = pick_key();
            if (item.action == ACTION_INSERT) begin
               key_pool.insert(key_pool.size(), item.key);
               if (key_pool.size() > POOL_MAX) key_pool.delete(0);
            end
            send_item(item, 1'b0, '0, pick_gap((n % 100) < 20));
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         flag_error($sformatf("%0d responses never arrived", pending_rsp.size()));
      end
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
